[src/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and payload types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES = 16384;
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WORD_W     = $clog2(HEAP_WORDS);
  localparam int SIZE_W     = WORD_W + 2;
  localparam int CNT_W      = WORD_W + 1;
  localparam int HDR_W      = SIZE_W + 1;
  localparam int RSZ_W      = 16;
  localparam int CMP_W      = (SIZE_W > RSZ_W) ? SIZE_W : RSZ_W;

  localparam logic [SIZE_W-1:0] WHOLE_SIZE = SIZE_W'(HEAP_BYTES - 4);

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_BADADDR = 2'd2;

  localparam logic REG_HEAP_BASE = 1'b0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [14:0] request_size;
    logic [31:0] free_address;
  } request_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

endpackage

[src/first_fit_heap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with an implicit chunk list kept in a header store.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. operation selects
//   allocate, free or reinitialize; the answer appears on result for one
//   cycle, marked by done, and the receiver cannot hold it off. The user must
//   write heap_base through the APB-style port only while the unit is idle;
//   the block itself does not enforce this.
// Walk:
//   the header store is read once per cycle, one chunk header per read;
//   allocate visits the chunks up to and including the fit (all of them
//   when nothing fits), and free reads the freed header, the free chunks it
//   absorbs and the used header that stops the walk, when there is one.
//   Zero-size allocate, rejected free, reinitialize and the undefined code
//   answer without a walk. One request is in flight at a time.
// Reset:
//   rst starts a clearing pass that writes every header word (HEAP_WORDS,
//   4096); busy stays high until it ends, config writes are still taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ffha_pkg::request_t request,
  output logic               done,
  output ffha_pkg::result_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ffha_pkg::*;

  logic [31:0] heap_base;

  ffha_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .heap_base (heap_base)
  );

  ffha_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .heap_base (heap_base),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  // a result only ever comes out as the unit returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // any failed request reports a null address
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STAT_OK)) |-> (result.result_address == 32'd0))
    else $error("nonzero address on failure");

  // zero-size allocate fails in the next cycle
  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.operation == OP_ALLOC) && (request.request_size == '0))
      |=> (done && (result.status == STAT_FAIL)))
    else $error("zero-size allocate not rejected");

  // an accepted free either walks or answers at once
  a_free_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.operation == OP_FREE)) |=> (busy || done))
    else $error("free request dropped");

endmodule

[src/ffha_ram.sv]
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ffha_cfg.sv]
// ----------------------------------------------------------------------------
// ffha_cfg
// APB-style register file holding the heap base address.
// ----------------------------------------------------------------------------
module ffha_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] heap_base
);
  import ffha_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_HEAP_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (wr_en) begin
      heap_base <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_HEAP_BASE) ? heap_base : 32'd0;

endmodule

[src/ffha_engine.sv]
// ----------------------------------------------------------------------------
// ffha_engine
// Header store and the sequencer that walks, splits and merges chunks.
// ----------------------------------------------------------------------------
module ffha_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ffha_pkg::request_t request,
  input  logic [31:0]        heap_base,
  output logic               busy,
  output logic               done,
  output ffha_pkg::result_t  result
);
  import ffha_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_SPLIT
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] clr_idx;
  logic [CNT_W-1:0]  c;
  logic [WORD_W-1:0] blk;
  logic [CMP_W-1:0]  size_q;
  logic              split_en;
  logic [WORD_W-1:0] split_addr;
  logic [SIZE_W-1:0] split_val;

  // memory ports
  logic              we;
  logic [WORD_W-1:0] waddr;
  logic [HDR_W-1:0]  wdata;
  logic [WORD_W-1:0] raddr;
  logic [HDR_W-1:0]  rdata;

  hdr_t              rd_hdr;
  logic              hdr_used;
  logic [CNT_W-1:0]  step;
  logic              past_end;
  logic              fit;
  logic [SIZE_W-1:0] rest;
  logic [CNT_W-1:0]  split_c;
  logic [CNT_W-1:0]  end_c;
  logic [CNT_W-1:0]  span;
  logic              free_stop;
  logic [31:0]       off;
  logic              off_ok;
  logic [WORD_W-1:0] off_blk;
  logic [RSZ_W-1:0]  rsz_sum;
  logic [CMP_W-1:0]  rsz;
  logic              accept;

  ffha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign rd_hdr   = hdr_t'(rdata);
  // the block being freed reads as unused when the free walk reads its header
  assign hdr_used = rd_hdr.used && !((state == S_FREE) && (c[WORD_W-1:0] == blk));
  assign step     = c + CNT_W'(1) + {1'b0, rd_hdr.size[SIZE_W-1:2]};
  assign past_end = (step >= CNT_W'(HEAP_WORDS));
  assign fit      = !hdr_used && (CMP_W'(rd_hdr.size) >= size_q);
  assign rest     = rd_hdr.size - size_q[SIZE_W-1:0];
  assign split_c  = c + CNT_W'(1) + {1'b0, size_q[SIZE_W-1:2]};

  assign free_stop = hdr_used || past_end;
  assign end_c     = hdr_used ? c : CNT_W'(HEAP_WORDS);
  assign span      = end_c - {1'b0, blk} - CNT_W'(1);

  assign off     = request.free_address - heap_base;
  assign off_ok  = (off >= 32'd4) && (off < 32'(HEAP_BYTES)) && (off[1:0] == 2'b00);
  assign off_blk = off[SIZE_W-1:2] - WORD_W'(1);

  // round request up to a word multiple
  assign rsz_sum = {1'b0, request.request_size} + RSZ_W'(3);
  assign rsz     = CMP_W'({rsz_sum[RSZ_W-1:2], 2'b00});

  always_comb begin
    raddr = c[WORD_W-1:0];
    case (state)
      S_IDLE: begin
        if (request.operation == OP_FREE) begin
          raddr = off_blk;
        end else begin
          raddr = '0;
        end
      end
      S_ALLOC, S_FREE: raddr = step[WORD_W-1:0];
      default: raddr = c[WORD_W-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = (clr_idx == '0) ? HDR_W'({1'b0, WHOLE_SIZE}) : '0;
      end
      S_IDLE: begin
        if (accept && (request.operation == OP_REINIT)) begin
          we    = 1'b1;
          waddr = '0;
          wdata = HDR_W'({1'b0, WHOLE_SIZE});
        end
      end
      S_ALLOC: begin
        if (fit) begin
          we    = 1'b1;
          waddr = c[WORD_W-1:0];
          wdata = HDR_W'({1'b1, size_q[SIZE_W-1:0]});
        end
      end
      S_FREE: begin
        if (free_stop) begin
          we    = 1'b1;
          waddr = blk;
          wdata = HDR_W'({1'b0, span[WORD_W-1:0], 2'b00});
        end
      end
      S_SPLIT: begin
        we    = split_en;
        waddr = split_addr;
        wdata = HDR_W'({1'b0, split_val});
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + WORD_W'(1);
          if (clr_idx == WORD_W'(HEAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            result.result_address <= '0;
            result.status         <= STAT_OK;
            size_q                <= rsz;
            case (request.operation)
              OP_ALLOC: begin
                c <= '0;
                if (request.request_size == '0) begin
                  result.status <= STAT_FAIL;
                  done          <= 1'b1;
                end else begin
                  state <= S_ALLOC;
                end
              end
              OP_FREE: begin
                c   <= {1'b0, off_blk};
                blk <= off_blk;
                if (off_ok) begin
                  state <= S_FREE;
                end else begin
                  result.status <= STAT_BADADDR;
                  done          <= 1'b1;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_ALLOC: begin
          if (fit) begin
            split_en   <= (rest >= SIZE_W'(4)) && (split_c < CNT_W'(HEAP_WORDS));
            split_addr <= split_c[WORD_W-1:0];
            split_val  <= rest - SIZE_W'(4);
            result.result_address <= heap_base + {30'(c) + 30'd1, 2'b00};
            state      <= S_SPLIT;
          end else if (past_end) begin
            result.status <= STAT_FAIL;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            c <= step;
          end
        end
        S_FREE: begin
          if (free_stop) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            c <= step;
          end
        end
        S_SPLIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
